>>> sv/scc_pkg.sv
// Shared types and constants for the single-cycle CPU core.
// Holds the opcode and item-kind enums, the request and response payload structs,
// and the register file reset pattern. Depends on nothing.
`default_nettype none

package scc_pkg;

   localparam int MEM_WORDS_DEFAULT = 16384;
   localparam int WORD_W            = 32;
   localparam int PC_W              = 16;
   localparam int REG_COUNT         = 16;
   localparam int REG_IDX_W         = 4;
   localparam int LOAD_ADDR_W       = 14;
   localparam int IMM_W             = 16;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_SLT  = 4'd2,
      OP_OR   = 4'd3,
      OP_AND  = 4'd4,
      OP_ADDI = 4'd5,
      OP_SLTI = 4'd6,
      OP_ORI  = 4'd7,
      OP_LUI  = 4'd8,
      OP_LW   = 4'd9,
      OP_SW   = 4'd10,
      OP_BEQ  = 4'd11,
      OP_JALR = 4'd12,
      OP_J    = 4'd13,
      OP_HALT = 4'd14,
      OP_NOP  = 4'd15
   } op_type;

   typedef enum logic {
      KIND_PRELOAD = 1'b0,
      KIND_EXEC    = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                 opcode;
      logic [LOAD_ADDR_W-1:0]   load_address;
      logic signed [WORD_W-1:0] load_data;
      logic [WORD_W-1:0]        instruction_word;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]          next_pc;
      logic                     halted;
      logic                     reg_written;
      logic [REG_IDX_W-1:0]     write_reg;
      logic signed [WORD_W-1:0] write_value;
      logic                     mem_fault;
   } rsp_type;

   // Register file contents right after reset.
   localparam logic [WORD_W-1:0] REG_INIT [REG_COUNT] = '{
      32'd3, 32'd1, 32'd1, 32'd3, 32'd2, 32'd2, 32'd3, 32'd3,
      32'd2, 32'd3, 32'd2, 32'd3, 32'd2, 32'd3, 32'd2, 32'd3
   };

endpackage

`default_nettype wire

>>> sv/scc_stream_if.sv
// Valid/ready stream interface used for the request and response channels.
// The payload type is a parameter; the core hands in structs from scc_pkg.
`default_nettype none

interface scc_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> sv/single_cycle_cpu_core_top.sv
// Single-cycle CPU core: one request per clock outside the clearing pass, unless responses stall.
// Pipeline: accept (register file read) -> execute (data memory access) -> response.
// Sustains one request per cycle while the response side keeps up; the register file and
// data memory each have one write port, and forwarding from the response stage keeps
// back-to-back requests exact. Reset clears the pc and register valid bits, then a pass
// over every MEM_WORDS entry zeroes the data memory while req_if.ready stays low.
`default_nettype none

module single_cycle_cpu_core_top #(
   parameter int MEM_WORDS = scc_pkg::MEM_WORDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   scc_stream_if.sink   req_if,
   scc_stream_if.source rsp_if
);

   // Index width; size bound for range checks and last index for the clearing pass, both 32 bits.
   localparam int                         ADDR_W   = $clog2(MEM_WORDS);
   localparam logic [scc_pkg::WORD_W-1:0] MEM_SIZE = 32'(MEM_WORDS);
   localparam logic [scc_pkg::WORD_W-1:0] MEM_LAST = 32'(MEM_WORDS - 1);

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   logic                           clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]              clr_addr_ff, clr_addr_in;
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s2_valid_ff, s2_valid_in;
   logic [scc_pkg::PC_W-1:0]       pc_ff, pc_in;
   logic [scc_pkg::REG_COUNT-1:0]  rf_valid_ff, rf_valid_in;
   logic                           wb_valid_ff, wb_valid_in;

   // Payload registers.
   scc_pkg::req_type               s1_req_ff, s1_req_in;
   scc_pkg::rsp_type               s2_rsp_ff, s2_rsp_in;
   logic                           s2_load_ff, s2_load_in;
   logic [scc_pkg::REG_IDX_W-1:0]  wb_reg_ff, wb_reg_in;
   logic [scc_pkg::WORD_W-1:0]     wb_value_ff, wb_value_in;
   logic                           rf_hit_a_ff, rf_hit_a_in;
   logic                           rf_hit_b_ff, rf_hit_b_in;
   logic [scc_pkg::WORD_W-1:0]     rf_rdata_a_ff, rf_rdata_b_ff;
   logic [scc_pkg::WORD_W-1:0]     dm_rdata_ff;

   // The two memories.
   logic [scc_pkg::WORD_W-1:0]     rf_ram_ff [scc_pkg::REG_COUNT];
   logic [scc_pkg::WORD_W-1:0]     dm_ram_ff [MEM_WORDS];

   // ------------------------------------------------------------------------
   // Handshake and pipeline flow
   // ------------------------------------------------------------------------
   logic req_fire, rsp_fire, s1_adv, s2_free, s1_hold;

   assign rsp_fire = rsp_if.valid && rsp_if.ready;
   assign s2_free  = !s2_valid_ff || rsp_if.ready;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign s1_hold  = s1_valid_ff && !s1_adv;

   // Outside the clearing pass, a new request is taken whenever the execute stage empties
   // or moves on, so requests flow every cycle unless the response side stalls.
   assign req_if.ready = !clr_busy_ff && !s1_hold;
   assign req_fire     = req_if.valid && req_if.ready;

   // ------------------------------------------------------------------------
   // Register file read addresses. The read is reissued every cycle, so a
   // request held in the execute stage always sees the latest commits.
   // ------------------------------------------------------------------------
   logic [scc_pkg::REG_IDX_W-1:0] rf_rd_a, rf_rd_b;

   always_comb begin
      if (s1_hold) begin
         rf_rd_a = s1_req_ff.instruction_word[23:20];
         rf_rd_b = s1_req_ff.instruction_word[19:16];
      end else begin
         rf_rd_a = req_if.payload.instruction_word[23:20];
         rf_rd_b = req_if.payload.instruction_word[19:16];
      end
   end

   // ------------------------------------------------------------------------
   // Execute stage: field decode and operand forwarding
   // ------------------------------------------------------------------------
   logic [scc_pkg::WORD_W-1:0]    iw;
   scc_pkg::op_type               op;
   logic [scc_pkg::REG_IDX_W-1:0] rs, rt, rd;
   logic [scc_pkg::IMM_W-1:0]     imm;
   logic [scc_pkg::WORD_W-1:0]    zx, sx;
   logic [scc_pkg::WORD_W-1:0]    opa, opb;
   logic [scc_pkg::WORD_W-1:0]    rsp_value;

   assign iw  = s1_req_ff.instruction_word;
   assign op  = scc_pkg::op_type'(iw[27:24]);
   assign rs  = iw[23:20];
   assign rt  = iw[19:16];
   assign rd  = iw[15:12];
   assign imm = iw[15:0];
   assign zx  = {16'd0, imm};
   assign sx  = {{16{imm[15]}}, imm};

   // Operand priority, youngest first: the pending write in the response
   // stage, then the write that committed at the same edge as the read,
   // then the memory itself (reset pattern for entries never written).
   always_comb begin
      opa = rf_hit_a_ff ? rf_rdata_a_ff : scc_pkg::REG_INIT[rs];
      if (wb_valid_ff && wb_reg_ff == rs) begin
         opa = wb_value_ff;
      end
      if (s2_valid_ff && s2_rsp_ff.reg_written && s2_rsp_ff.write_reg == rs) begin
         opa = rsp_value;
      end
      opb = rf_hit_b_ff ? rf_rdata_b_ff : scc_pkg::REG_INIT[rt];
      if (wb_valid_ff && wb_reg_ff == rt) begin
         opb = wb_value_ff;
      end
      if (s2_valid_ff && s2_rsp_ff.reg_written && s2_rsp_ff.write_reg == rt) begin
         opb = rsp_value;
      end
   end

   // ------------------------------------------------------------------------
   // Execute stage: operation
   // ------------------------------------------------------------------------
   logic [scc_pkg::WORD_W-1:0]    mem_addr;
   logic                          addr_ok;
   logic [scc_pkg::PC_W-1:0]      pc1;
   logic [scc_pkg::PC_W-1:0]      npc;
   logic                          halted, wr, fault, is_load, store_en;
   logic [scc_pkg::REG_IDX_W-1:0] wreg;
   logic [scc_pkg::WORD_W-1:0]    wval;
   logic [scc_pkg::WORD_W-1:0]    pre_addr;
   logic                          preload_ok;

   assign mem_addr = opa + sx;
   // Addresses are signed; anything negative or past the end faults.
   assign addr_ok  = !mem_addr[scc_pkg::WORD_W-1] && (mem_addr < MEM_SIZE);
   assign pc1      = pc_ff + 16'd1;
   assign pre_addr = 32'(s1_req_ff.load_address);
   assign preload_ok = (s1_req_ff.opcode == scc_pkg::KIND_PRELOAD) && (pre_addr < MEM_SIZE);

   always_comb begin
      npc      = pc1;
      halted   = 1'b0;
      wr       = 1'b0;
      fault    = 1'b0;
      is_load  = 1'b0;
      store_en = 1'b0;
      wreg     = '0;
      wval     = '0;
      unique case (op)
         scc_pkg::OP_ADD: begin
            wr = 1'b1; wreg = rd; wval = opa + opb;
         end
         scc_pkg::OP_SUB: begin
            wr = 1'b1; wreg = rd; wval = opa - opb;
         end
         scc_pkg::OP_SLT: begin
            wr = 1'b1; wreg = rd; wval = {31'd0, $signed(opa) < $signed(opb)};
         end
         scc_pkg::OP_OR: begin
            wr = 1'b1; wreg = rd; wval = opa | opb;
         end
         scc_pkg::OP_AND: begin
            wr = 1'b1; wreg = rd; wval = opa & opb;
         end
         scc_pkg::OP_ADDI: begin
            wr = 1'b1; wreg = rt; wval = opa + sx;
         end
         scc_pkg::OP_SLTI: begin
            wr = 1'b1; wreg = rt; wval = {31'd0, $signed(opa) < $signed(sx)};
         end
         scc_pkg::OP_ORI: begin
            wr = 1'b1; wreg = rt; wval = opa | zx;
         end
         scc_pkg::OP_LUI: begin
            wr = 1'b1; wreg = rt; wval = {imm, 16'd0};
         end
         scc_pkg::OP_LW: begin
            // The loaded word joins in the response stage; a faulting load
            // writes zero.
            wr = 1'b1; wreg = rt; is_load = 1'b1; fault = !addr_ok;
         end
         scc_pkg::OP_SW: begin
            store_en = addr_ok; fault = !addr_ok;
         end
         scc_pkg::OP_BEQ: begin
            if (opa == opb) begin
               npc = pc1 + imm;
            end
         end
         scc_pkg::OP_JALR: begin
            wr = 1'b1; wreg = rt; wval = {16'd0, pc1}; npc = opa[scc_pkg::PC_W-1:0];
         end
         scc_pkg::OP_J: begin
            npc = imm;
         end
         scc_pkg::OP_HALT: begin
            halted = 1'b1; npc = pc_ff;
         end
         scc_pkg::OP_NOP: begin
            npc = pc1;
         end
      endcase
      // A preload leaves the pc alone and reports nothing else.
      if (s1_req_ff.opcode == scc_pkg::KIND_PRELOAD) begin
         npc      = pc_ff;
         halted   = 1'b0;
         wr       = 1'b0;
         fault    = 1'b0;
         is_load  = 1'b0;
         store_en = 1'b0;
         wreg     = '0;
         wval     = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Data memory port: clearing pass, preload or store write, load read.
   // ------------------------------------------------------------------------
   logic                       dm_we;
   logic [ADDR_W-1:0]          dm_wr_idx, dm_rd_idx;
   logic [scc_pkg::WORD_W-1:0] dm_wdata;

   assign dm_we     = s1_adv && (preload_ok || store_en);
   assign dm_rd_idx = mem_addr[ADDR_W-1:0];
   assign dm_wr_idx = (s1_req_ff.opcode == scc_pkg::KIND_PRELOAD) ?
                      pre_addr[ADDR_W-1:0] : mem_addr[ADDR_W-1:0];
   assign dm_wdata  = (s1_req_ff.opcode == scc_pkg::KIND_PRELOAD) ?
                      s1_req_ff.load_data : opb;

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dm_ram_ff[clr_addr_ff] <= '0;
      end else if (dm_we) begin
         dm_ram_ff[dm_wr_idx] <= dm_wdata;
      end
      // Only one request sits in execute at a time, so a load never races a
      // store of an older request: that store landed on an earlier edge.
      if (s1_adv) begin
         dm_rdata_ff <= dm_ram_ff[dm_rd_idx];
      end
   end

   // ------------------------------------------------------------------------
   // Response stage and register file write-back
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_value = s2_rsp_ff.write_value;
      if (s2_load_ff) begin
         rsp_value = dm_rdata_ff;
      end
   end

   always_comb begin
      rsp_if.payload             = s2_rsp_ff;
      rsp_if.payload.write_value = rsp_value;
   end
   assign rsp_if.valid = s2_valid_ff;

   logic rf_we;
   assign rf_we = rsp_fire && s2_rsp_ff.reg_written;

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_ram_ff[s2_rsp_ff.write_reg] <= rsp_value;
      end
      rf_rdata_a_ff <= rf_ram_ff[rf_rd_a];
      rf_rdata_b_ff <= rf_ram_ff[rf_rd_b];
   end

   // ------------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------------
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (32'(clr_addr_ff) == MEM_LAST) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
      end

      s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_req_in   = req_fire ? req_if.payload : s1_req_ff;

      s2_valid_in = s1_adv ? 1'b1 : (rsp_fire ? 1'b0 : s2_valid_ff);
      s2_rsp_in   = s2_rsp_ff;
      s2_load_in  = s2_load_ff;
      if (s1_adv) begin
         s2_rsp_in.next_pc     = npc;
         s2_rsp_in.halted      = halted;
         s2_rsp_in.reg_written = wr;
         s2_rsp_in.write_reg   = wreg;
         s2_rsp_in.write_value = wval;
         s2_rsp_in.mem_fault   = fault;
         s2_load_in            = is_load && addr_ok;
      end

      pc_in = s1_adv ? npc : pc_ff;

      rf_valid_in = rf_valid_ff;
      if (rf_we) begin
         rf_valid_in[s2_rsp_ff.write_reg] = 1'b1;
      end
      // The read issued at this edge misses the write committed at it, so
      // that write is kept in the write-back registers as a forwarding source.
      wb_valid_in = rf_we;
      wb_reg_in   = s2_rsp_ff.write_reg;
      wb_value_in = rsp_value;
      rf_hit_a_in = rf_valid_ff[rf_rd_a];
      rf_hit_b_in = rf_valid_ff[rf_rd_b];
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         pc_ff       <= '0;
         rf_valid_ff <= '0;
         wb_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         pc_ff       <= pc_in;
         rf_valid_ff <= rf_valid_in;
         wb_valid_ff <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff   <= s1_req_in;
      s2_rsp_ff   <= s2_rsp_in;
      s2_load_ff  <= s2_load_in;
      wb_reg_ff   <= wb_reg_in;
      wb_value_ff <= wb_value_in;
      rf_hit_a_ff <= rf_hit_a_in;
      rf_hit_b_ff <= rf_hit_b_in;
   end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for single_cycle_cpu_core_top: preloads and instructions go in,
// and each response is checked against a directed expectation or an architectural shadow model.
// Depends on scc_pkg (types, opcodes, register reset pattern) and scc_stream_if.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEM_WORDS = scc_pkg::MEM_WORDS_DEFAULT;
   localparam int ADDR_W    = $clog2(MEM_WORDS);

   // One row of the directed table. When has_want is set the expected response is
   // taken from the row itself; otherwise it comes from the shadow model.
   typedef struct {
      scc_pkg::req_type req;
      bit               has_want;
      scc_pkg::rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   scc_stream_if #(.payload_type(scc_pkg::req_type)) req_if ();
   scc_stream_if #(.payload_type(scc_pkg::rsp_type)) rsp_if ();

   single_cycle_cpu_core_top #(.MEM_WORDS(MEM_WORDS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Architectural state as the core should see it: register file, data memory and pc.
   logic [scc_pkg::WORD_W-1:0] shadow_regs [scc_pkg::REG_COUNT];
   logic [scc_pkg::WORD_W-1:0] shadow_mem [MEM_WORDS];
   logic [scc_pkg::PC_W-1:0]   shadow_pc;

   // Responses that accepted requests are still owed, oldest first.
   scc_pkg::rsp_type retire_q [$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int requests_sent  = 0;
   bit failed         = 1'b0;

   stim_row_type directed_rows [25];

   // Free-running 100 MHz clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the core hangs or drops a response.
   initial begin
      #5_000_000;
      $display("single_cycle_cpu_core_top test failed");
      $finish;
   end

   function automatic scc_pkg::req_type exec_raw(logic [scc_pkg::WORD_W-1:0] iw);
      scc_pkg::req_type r;
      r = '0;
      r.opcode = scc_pkg::KIND_EXEC;
      r.instruction_word = iw;
      return r;
   endfunction

   // Builds an instruction word. For register-register operations the destination
   // register sits in the top nibble of the immediate.
   function automatic scc_pkg::req_type exec_req(scc_pkg::op_type op, int rs, int rt,
                                                 logic [scc_pkg::IMM_W-1:0] imm);
      return exec_raw({4'h0, op, 4'(rs), 4'(rt), imm});
   endfunction

   function automatic scc_pkg::req_type preload_req(logic [scc_pkg::LOAD_ADDR_W-1:0] addr,
                                                    logic [scc_pkg::WORD_W-1:0] data);
      scc_pkg::req_type r;
      r = '0;
      r.opcode = scc_pkg::KIND_PRELOAD;
      r.load_address = addr;
      r.load_data = data;
      return r;
   endfunction

   function automatic scc_pkg::rsp_type make_rsp(int npc, int halt, int wr, int wreg,
                                                 logic [scc_pkg::WORD_W-1:0] wval,
                                                 int fault);
      scc_pkg::rsp_type o;
      o.next_pc     = 16'(npc);
      o.halted      = 1'(halt);
      o.reg_written = 1'(wr);
      o.write_reg   = 4'(wreg);
      o.write_value = wval;
      o.mem_fault   = 1'(fault);
      return o;
   endfunction

   // Retires one request on the shadow state and returns the response it must produce.
   function automatic scc_pkg::rsp_type retire(scc_pkg::req_type r);
      scc_pkg::rsp_type           o;
      scc_pkg::op_type            op;
      logic [3:0]                 rs, rt, rd;
      logic [scc_pkg::IMM_W-1:0]  zx;
      logic [scc_pkg::WORD_W-1:0] sx, a, b, addr;
      logic [scc_pkg::PC_W-1:0]   pc_next;
      bit                         addr_ok;

      o = '0;
      o.next_pc = shadow_pc;
      // A preload only touches memory; the pc does not move.
      if (r.opcode == scc_pkg::KIND_PRELOAD) begin
         if (r.load_address < MEM_WORDS)
            shadow_mem[r.load_address] = r.load_data;
         return o;
      end

      op      = scc_pkg::op_type'(r.instruction_word[27:24]);
      rs      = r.instruction_word[23:20];
      rt      = r.instruction_word[19:16];
      rd      = r.instruction_word[15:12];
      zx      = r.instruction_word[15:0];
      sx      = {{16{zx[15]}}, zx};
      a       = shadow_regs[rs];
      b       = shadow_regs[rt];
      addr    = a + sx;
      addr_ok = (addr[31] == 1'b0) && (addr < MEM_WORDS);
      pc_next = shadow_pc + 16'd1;
      o.next_pc = pc_next;

      case (op) inside
         scc_pkg::OP_ADD, scc_pkg::OP_SUB, scc_pkg::OP_SLT, scc_pkg::OP_OR,
         scc_pkg::OP_AND: begin
            o.reg_written = 1'b1;
            o.write_reg   = rd;
            case (op)
               scc_pkg::OP_ADD: o.write_value = a + b;
               scc_pkg::OP_SUB: o.write_value = a - b;
               scc_pkg::OP_SLT: o.write_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
               scc_pkg::OP_OR:  o.write_value = a | b;
               default:         o.write_value = a & b;
            endcase
         end
         scc_pkg::OP_ADDI, scc_pkg::OP_SLTI, scc_pkg::OP_ORI, scc_pkg::OP_LUI: begin
            o.reg_written = 1'b1;
            o.write_reg   = rt;
            case (op)
               scc_pkg::OP_ADDI: o.write_value = a + sx;
               scc_pkg::OP_SLTI: o.write_value = ($signed(a) < $signed(sx)) ? 32'd1 : 32'd0;
               scc_pkg::OP_ORI:  o.write_value = a | {16'h0, zx};
               default:          o.write_value = {zx, 16'h0};
            endcase
         end
         scc_pkg::OP_LW: begin
            o.reg_written = 1'b1;
            o.write_reg   = rt;
            if (addr_ok)
               o.write_value = shadow_mem[addr[ADDR_W-1:0]];
            else
               o.mem_fault = 1'b1;
         end
         scc_pkg::OP_SW: begin
            if (addr_ok)
               shadow_mem[addr[ADDR_W-1:0]] = b;
            else
               o.mem_fault = 1'b1;
         end
         scc_pkg::OP_BEQ: begin
            if (a == b)
               o.next_pc = pc_next + sx[15:0];
         end
         scc_pkg::OP_JALR: begin
            o.reg_written = 1'b1;
            o.write_reg   = rt;
            o.write_value = {16'h0, pc_next};
            o.next_pc     = a[15:0];
         end
         scc_pkg::OP_J: o.next_pc = zx;
         scc_pkg::OP_HALT: begin
            o.halted  = 1'b1;
            o.next_pc = shadow_pc;
         end
         default: ;
      endcase

      if (o.reg_written)
         shadow_regs[o.write_reg] = o.write_value;
      shadow_pc = o.next_pc;
      return o;
   endfunction

   // Offers one request, holding valid until the core takes it. The expected response
   // is queued at the accepting edge, before that response can arrive.
   task automatic send_request(scc_pkg::req_type r, bit has_want = 1'b0,
                               scc_pkg::rsp_type want = '0);
      scc_pkg::rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do
         @(posedge clock);
      while (!req_if.ready);
      predicted = retire(r);
      retire_q.push_back(has_want ? want : predicted);
      requests_sent++;
   endtask

   // Random traffic. Most of it is plain random instruction words, 15 percent is preloads, and a
   // quarter is a well-formed address setup (lui/ori to build a base) followed by loads and
   // stores around that base, so that memory is actually hit and not just faulted.
   task automatic run_random(int count);
      int                         target;
      int                         kind;
      int                         base_reg;
      logic [scc_pkg::WORD_W-1:0] iw;
      target = requests_sent + count;
      while (requests_sent < target) begin
         kind = $urandom_range(99);
         if (kind < 15) begin
            send_request(preload_req(14'($urandom_range(1) ? $urandom_range(63) : $urandom),
                                     $urandom));
         end else if (kind < 40) begin
            base_reg = $urandom_range(15);
            send_request(exec_req(scc_pkg::OP_LUI, $urandom_range(15), base_reg, 16'h0000));
            send_request(exec_req(scc_pkg::OP_ORI, base_reg, base_reg,
                                  16'($urandom_range(1) ? $urandom_range(63)
                                                        : $urandom_range(MEM_WORDS - 1))));
            repeat ($urandom_range(1, 4))
               send_request(exec_req($urandom_range(1) ? scc_pkg::OP_LW : scc_pkg::OP_SW,
                                     base_reg, $urandom_range(15),
                                     16'($urandom_range(16) - 8)));
         end else begin
            iw = $urandom;
            // Half the time keep the immediate small so branches stay local and
            // comparisons land near zero.
            if ($urandom_range(1))
               iw[15:0] = 16'($urandom_range(32) - 16);
            send_request(exec_raw(iw));
         end
      end
   endtask

   // Response side: samples at each rising edge, then decides whether to stall the
   // next cycle. Only one nonblocking write to ready happens per edge.
   task automatic check_field(string name, logic [scc_pkg::WORD_W-1:0] want,
                              logic [scc_pkg::WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failed = 1'b1;
      end
   endtask

   initial begin
      scc_pkg::rsp_type want;
      scc_pkg::rsp_type got;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (retire_q.size() == 0) begin
               $error("response with no request outstanding: next_pc 0x%0h", got.next_pc);
               failed = 1'b1;
            end else begin
               want = retire_q.pop_front();
               check_field("next_pc",     32'(want.next_pc),     32'(got.next_pc));
               check_field("halted",      32'(want.halted),      32'(got.halted));
               check_field("reg_written", 32'(want.reg_written), 32'(got.reg_written));
               check_field("write_reg",   32'(want.write_reg),   32'(got.write_reg));
               check_field("write_value", want.write_value,      got.write_value);
               check_field("mem_fault",   32'(want.mem_fault),   32'(got.mem_fault));
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Main sequence: reset, directed table, four random phases with different
   // idling patterns, then drain.
   initial begin
      int send_pct [4];
      int stall_pct [4];

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;

      for (int i = 0; i < scc_pkg::REG_COUNT; i++)
         shadow_regs[i] = scc_pkg::REG_INIT[i];
      for (int i = 0; i < MEM_WORDS; i++)
         shadow_mem[i] = '0;
      shadow_pc = '0;

      // Register file after reset is 3,1,1,3,2,2,3,3,2,3,2,3,2,3,2,3. The rows walk
      // every operation, both immediate extremes, preloads at both ends of memory,
      // a load below and a store past the end of memory, a taken and an untaken branch,
      // a pc wrap from 0xFFFF to 0, a no-op with the unused top bits set, and halt.
      directed_rows = '{
         '{exec_req(scc_pkg::OP_ADD,  1, 2, 16'h0000), 1'b1,
           make_rsp(1, 0, 1, 0, 32'd2, 0)},
         '{exec_req(scc_pkg::OP_SUB,  4, 3, 16'h5000), 1'b1,
           make_rsp(2, 0, 1, 5, 32'hFFFF_FFFF, 0)},
         '{exec_req(scc_pkg::OP_SLT,  5, 1, 16'h6000), 1'b1,
           make_rsp(3, 0, 1, 6, 32'd1, 0)},
         '{exec_req(scc_pkg::OP_SLTI, 1, 7, 16'h8000), 1'b1,
           make_rsp(4, 0, 1, 7, 32'd0, 0)},
         '{exec_req(scc_pkg::OP_LUI,  0, 8, 16'hFFFF), 1'b0, '0},
         '{exec_req(scc_pkg::OP_ORI,  8, 9, 16'hFFFF), 1'b0, '0},
         '{exec_req(scc_pkg::OP_AND,  9, 5, 16'hA000), 1'b0, '0},
         '{exec_req(scc_pkg::OP_OR,   0, 6, 16'hB000), 1'b0, '0},
         '{exec_req(scc_pkg::OP_ADDI, 8, 12, 16'h7FFF), 1'b0, '0},
         '{preload_req(14'd0, 32'h8000_0000), 1'b1, make_rsp(9, 0, 0, 0, 32'd0, 0)},
         '{preload_req(14'h3FFF, 32'h7FFF_FFFF), 1'b1, make_rsp(9, 0, 0, 0, 32'd0, 0)},
         '{exec_req(scc_pkg::OP_LUI,  0, 14, 16'h0000), 1'b0, '0},
         '{exec_req(scc_pkg::OP_LW,  14, 13, 16'h0000), 1'b0, '0},
         '{exec_req(scc_pkg::OP_LW,  14, 15, 16'hFFFF), 1'b1,
           make_rsp(12, 0, 1, 15, 32'd0, 1)},
         '{exec_req(scc_pkg::OP_SW,  14, 5, 16'h4000), 1'b1,
           make_rsp(13, 0, 0, 0, 32'd0, 1)},
         '{exec_req(scc_pkg::OP_ORI, 14, 14, 16'h3FFF), 1'b0, '0},
         '{exec_req(scc_pkg::OP_LW,  14, 13, 16'h0000), 1'b0, '0},
         '{exec_req(scc_pkg::OP_SW,  14, 5, 16'hFFFF), 1'b0, '0},
         '{exec_req(scc_pkg::OP_LW,  14, 3, 16'hFFFF), 1'b0, '0},
         '{exec_req(scc_pkg::OP_BEQ,  9, 10, 16'hFFF0), 1'b0, '0},
         '{exec_req(scc_pkg::OP_BEQ,  0, 1, 16'h0005), 1'b0, '0},
         '{exec_req(scc_pkg::OP_JALR, 9, 2, 16'h0000), 1'b0, '0},
         '{exec_req(scc_pkg::OP_J,    0, 0, 16'hFFFF), 1'b0, '0},
         '{exec_raw(32'hFFFF_FFFF), 1'b1, make_rsp(0, 0, 0, 0, 32'd0, 0)},
         '{exec_raw({4'h0, scc_pkg::OP_HALT, 24'h0}), 1'b1, make_rsp(0, 1, 0, 0, 32'd0, 0)}
      };

      send_pct  = '{0, 74, 0, 26};
      stall_pct = '{0, 0, 74, 26};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The core clears its data memory after reset with ready low; the first
      // handshake simply waits that out.
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].has_want, directed_rows[i].want);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct[p];
         rsp_stall_pct = stall_pct[p];
         run_random(150);
      end

      req_if.valid  <= 1'b0;
      rsp_stall_pct = 0;
      while (retire_q.size() != 0)
         @(posedge clock);
      // Keep the clock running to catch any stray response after the queue drains.
      repeat (20) @(posedge clock);

      if (!failed)
         $display("single_cycle_cpu_core_top test passed");
      else
         $display("single_cycle_cpu_core_top test failed");
      $finish;
   end

endmodule
